>>> hdl/ecdb_pkg.sv
// Package for the encoder-count-to-direction-button block.
// Holds register index codes, the direction type and the state and config structs.
// No dependencies.
`default_nettype none

package ecdb_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADZONE   = 2'd0,
    CFG_HOLD_MS    = 2'd1,
    CFG_CLEAR_REV  = 2'd2,
    CFG_INVERT_OUT = 2'd3
  } cfg_idx_e;

  typedef logic signed [1:0] dir_t;

  localparam dir_t DirNone = 2'sd0;
  localparam dir_t DirPos  = 2'sd1;
  localparam dir_t DirNeg  = -2'sd1;

  typedef struct packed {
    logic [6:0]  deadzone;
    logic [15:0] hold_ms;
    logic        clear_on_reverse;
    logic        invert_output;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  centre;
    logic [31:0] deadline;
    dir_t        held_direction;
  } state_t;

endpackage

`default_nettype wire

>>> hdl/ecdb_step.sv
// One poll of the direction tracker: next state and reported direction.
// Purely combinational; depends on ecdb_pkg.
`default_nettype none

module ecdb_step (
  input  var ecdb_pkg::cfg_t   cfg_i,
  input  var ecdb_pkg::state_t state_i,
  input  wire logic [7:0]      observed_count_i,
  input  wire logic [31:0]     now_ms_i,
  output var ecdb_pkg::state_t state_o,
  output var ecdb_pkg::dir_t   direction_o
);

  logic [7:0]        diff;
  logic signed [8:0] delta;
  logic signed [8:0] dz;
  ecdb_pkg::dir_t    dir;
  ecdb_pkg::dir_t    held;
  ecdb_pkg::dir_t    neg_held;
  logic              expired;

  assign diff  = observed_count_i - state_i.centre;
  assign delta = {diff[7], diff};
  assign dz    = {2'b00, cfg_i.deadzone};

  always_comb begin
    if (delta >= dz) begin
      dir = ecdb_pkg::DirPos;
    end else if (delta <= -dz) begin
      dir = ecdb_pkg::DirNeg;
    end else begin
      dir = ecdb_pkg::DirNone;
    end
  end

  // plain unsigned compare, no allowance for time wrap
  assign expired = (state_i.deadline != 32'd0) && (now_ms_i >= state_i.deadline);

  always_comb begin
    state_o = state_i;
    held    = state_i.held_direction;
    if (dir != ecdb_pkg::DirNone) begin
      state_o.centre   = observed_count_i;
      state_o.deadline = now_ms_i + {16'd0, cfg_i.hold_ms};
    end else if (expired) begin
      held             = ecdb_pkg::DirNone;
      state_o.centre   = observed_count_i;
      state_o.deadline = 32'd0;
    end

    neg_held = -held;
    if ((dir == neg_held) && cfg_i.clear_on_reverse) begin
      state_o.held_direction = dir;
      direction_o            = ecdb_pkg::DirNone;
    end else begin
      if (dir != ecdb_pkg::DirNone) begin
        held = dir;
      end
      state_o.held_direction = held;
      direction_o            = cfg_i.invert_output ? -held : held;
    end
  end

endmodule

`default_nettype wire

>>> hdl/encoder_count_to_direction_button.sv
// Top level: encoder count to direction button.
// Throughput: one poll per cycle unless the output stalls with both registers full;
// the state update is a single pass through ecdb_step.
// Input register then result register; the input stalls only when both are full
// and the output is stalled.
// Reset clears state to centre 0, deadline not armed, no direction, registers to defaults.
`default_nettype none

module encoder_count_to_direction_button_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output wire logic                          cfg_ready_o,
  input  wire logic [ecdb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ecdb_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output wire logic                          in_stall_o,
  input  wire logic [7:0]                    in_observed_count_i,
  input  wire logic [31:0]                   in_now_ms_i,
  output wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output wire logic signed [1:0]             out_direction_o
);

  ecdb_pkg::cfg_t   cfg_q;
  ecdb_pkg::state_t state_q, state_d;
  ecdb_pkg::dir_t   dir_d, dir_q;
  logic             s1_valid_q;
  logic [7:0]       s1_count_q;
  logic [31:0]      s1_now_q;
  logic             out_valid_q;
  logic             out_free;
  logic             s1_adv;
  logic             in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone         <= 7'd4;
      cfg_q.hold_ms          <= 16'd100;
      cfg_q.clear_on_reverse <= 1'b1;
      cfg_q.invert_output    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ecdb_pkg::CFG_DEADZONE:   cfg_q.deadzone         <= cfg_data_i[6:0];
        ecdb_pkg::CFG_HOLD_MS:    cfg_q.hold_ms          <= cfg_data_i;
        ecdb_pkg::CFG_CLEAR_REV:  cfg_q.clear_on_reverse <= cfg_data_i[0];
        ecdb_pkg::CFG_INVERT_OUT: cfg_q.invert_output    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // advance the input register when the result register is empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_count_q <= in_observed_count_i;
      s1_now_q   <= in_now_ms_i;
    end
  end

  ecdb_step u_step (
    .cfg_i            (cfg_q),
    .state_i          (state_q),
    .observed_count_i (s1_count_q),
    .now_ms_i         (s1_now_q),
    .state_o          (state_d),
    .direction_o      (dir_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      dir_q <= dir_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_direction_o = dir_q;

endmodule

`default_nettype wire

>>> hdl/ecdb_checker.sv
// Port-level checks for the direction button core, bound to the top level.
// Depends on encoder_count_to_direction_button_core.
`default_nettype none

module ecdb_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic signed [1:0] out_direction_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_direction_o))
    else $error("stalled result changed");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_direction_o != 2'b10)
    else $error("direction code out of range");

  // an accepted transaction passes the input register and then the result register to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("result missing after accepted transaction");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind encoder_count_to_direction_button_core ecdb_checker u_ecdb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_direction_o (out_direction_o)
);

`default_nettype wire

>>> tb/sv/tb_encoder_count_to_direction_button_core.sv
// Self-checking testbench for encoder_count_to_direction_button_core: polls in, directions out,
// each result compared with a cycle-free predictor of the centre, deadline and held direction.
// Depends on ecdb_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_encoder_count_to_direction_button_core;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [7:0]     count;
    logic [31:0]    now;
    ecdb_pkg::dir_t dir;
  } poll_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  wire         cfg_ready_o;
  ecdb_pkg::cfg_idx_e cfg_index_i = ecdb_pkg::CFG_DEADZONE;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  wire         in_stall_o;
  logic [7:0]  in_observed_count_i = '0;
  logic [31:0] in_now_ms_i = '0;
  wire         out_valid_o;
  logic        out_stall_i = 1'b0;
  wire logic signed [1:0] out_direction_o;

  // Predictor copy of the registers and state, at their reset values
  logic [6:0]  dz_cfg = 7'd4;
  logic [15:0] sustain_cfg = 16'd100;
  logic        clear_rev_cfg = 1'b1;
  logic        invert_cfg = 1'b1;
  logic [7:0]  track_centre = '0;
  logic [31:0] track_deadline = '0;
  ecdb_pkg::dir_t held_dir = ecdb_pkg::DirNone;

  poll_result_t expected_polls[$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  logic [7:0]  stim_count = '0;
  logic [31:0] stim_now = '0;

  int          hold_request = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  int          free_left = 0;

  encoder_count_to_direction_button_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_observed_count_i(in_observed_count_i),
    .in_now_ms_i        (in_now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_direction_o    (out_direction_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic ecdb_pkg::dir_t next_direction(logic [7:0] count, logic [31:0] now);
    logic [7:0] diff;
    int         delta;
    int         step_dir;
    int         held;
    diff = count - track_centre;
    delta = int'($signed(diff));
    step_dir = 0;
    if (delta >= int'(dz_cfg)) begin
      step_dir = 1;
    end else if (delta <= -int'(dz_cfg)) begin
      step_dir = -1;
    end
    if (step_dir != 0) begin
      track_centre = count;
      track_deadline = now + 32'(sustain_cfg);
    end else if (track_deadline != 0 && now >= track_deadline) begin
      // sustain over: drop the direction and let the centre follow
      held_dir = ecdb_pkg::DirNone;
      track_centre = count;
      track_deadline = '0;
    end
    held = int'(held_dir);
    if (step_dir == -held && clear_rev_cfg) begin
      held_dir = ecdb_pkg::dir_t'(step_dir);
      return ecdb_pkg::DirNone;
    end
    if (step_dir != 0) begin
      held_dir = ecdb_pkg::dir_t'(step_dir);
    end
    return invert_cfg ? -held_dir : held_dir;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ecdb_pkg::CFG_DEADZONE:   dz_cfg = cfg_data_i[6:0];
        ecdb_pkg::CFG_HOLD_MS:    sustain_cfg = cfg_data_i;
        ecdb_pkg::CFG_CLEAR_REV:  clear_rev_cfg = cfg_data_i[0];
        ecdb_pkg::CFG_INVERT_OUT: invert_cfg = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : predict_polls
    poll_result_t item;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      item.count = in_observed_count_i;
      item.now = in_now_ms_i;
      item.dir = next_direction(in_observed_count_i, in_now_ms_i);
      expected_polls.push_back(item);
    end
  end

  always @(posedge clk_i) begin : check_directions
    poll_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_polls.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
          $display("cycle %0d: direction %0d with no poll outstanding",
                   cycle_count, out_direction_o);
        end
      end else begin
        want = expected_polls.pop_front();
        if (out_direction_o !== want.dir) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("cycle %0d: count %0d now %0d: direction expected %0d, got %0d",
                     cycle_count, want.count, want.now, want.dir, out_direction_o);
          end
        end
      end
    end
  end

  // Output stall: a requested long hold-off first, else random runs of stall and free flow
  always @(posedge clk_i) begin : stall_gen
    int r;
    if (hold_request != 0) begin
      hold_left <= hold_request;
      hold_request <= 0;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (free_left != 0) begin
      free_left <= free_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        free_left <= $urandom_range(0, 25);
        out_stall_i <= 1'b0;
      end else if (r < 93) begin
        stall_left <= $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_left <= $urandom_range(8, 30);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_encoder_count_to_direction_button_core: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offer one poll and hold it until the transaction completes; keep valid high when gap is 0
  task automatic send_poll(input logic [7:0] count, input logic [31:0] now, input int gap);
    bit stalled;
    in_valid_i <= 1'b1;
    in_observed_count_i <= count;
    in_now_ms_i <= now;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input ecdb_pkg::cfg_idx_e idx, input logic [15:0] value);
    bit ready;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i);
      ready = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every outstanding direction, then let the pipeline empty
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    // let the predictor log the last accepted transaction first
    @(negedge clk_i);
    while (expected_polls.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Advance the encoder and clock mostly in small steps around the deadzone, sometimes jump
  task automatic advance_stimulus();
    int step;
    int dz;
    dz = int'(dz_cfg);
    if ($urandom_range(0, 99) < 10) begin
      stim_count = 8'($urandom);
      stim_now = $urandom;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: step = $urandom_range(0, 15);
        6, 7:             step = $urandom_range(0, 300);
        8:                step = int'(sustain_cfg) + int'($urandom_range(0, 2)) - 1;
        default:          step = $urandom_range(0, 100000);
      endcase
      stim_now = stim_now + 32'(step);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: step = $urandom_range(0, dz + 2);
        6:                step = 0;
        7:                step = dz;
        8:                step = (dz > 0) ? dz - 1 : 0;
        default:          step = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 1) != 0) begin
        step = -step;
      end
      stim_count = stim_count + 8'(step);
    end
  endtask

  task automatic test_reset_defaults();
    send_poll(8'd0, 32'd0, 0);
    send_poll(8'd4, 32'd10, 1);
    send_poll(8'd255, 32'd20, 0);
    send_poll(8'd255, 32'd200, 2);
    send_poll(8'd254, 32'd201, 0);
  endtask

  task automatic test_register_extremes();
    // zero deadzone, zero sustain, no clear, no invert; upper data bits must be ignored
    settle_idle();
    write_register(ecdb_pkg::CFG_DEADZONE, 16'hFF80);
    write_register(ecdb_pkg::CFG_HOLD_MS, 16'h0000);
    write_register(ecdb_pkg::CFG_CLEAR_REV, 16'hFFFE);
    write_register(ecdb_pkg::CFG_INVERT_OUT, 16'h0002);
    send_poll(8'd255, 32'd300, 0);
    send_poll(8'd255, 32'd300, 0);
    send_poll(8'd0, 32'd301, 1);
    send_poll(8'h81, 32'd302, 0);
    // widest deadzone and sustain; sum of deadline lands on zero
    settle_idle();
    write_register(ecdb_pkg::CFG_DEADZONE, 16'hFFFF);
    write_register(ecdb_pkg::CFG_HOLD_MS, 16'hFFFF);
    write_register(ecdb_pkg::CFG_CLEAR_REV, 16'h0001);
    write_register(ecdb_pkg::CFG_INVERT_OUT, 16'hFFFF);
    send_poll(8'd127, 32'd1000, 0);
    send_poll(8'd255, 32'd1001, 0);
    send_poll(8'd0, 32'hFFFF_0001, 2);
    send_poll(8'd127, 32'hFFFF_0001, 0);
    send_poll(8'd127, 32'hFFFF_FFFF, 0);
    // deadline wraps past zero, so the plain compare expires it at once
    settle_idle();
    write_register(ecdb_pkg::CFG_HOLD_MS, 16'd100);
    send_poll(8'd0, 32'hFFFF_FFF0, 0);
    send_poll(8'd0, 32'hFFFF_FFF1, 0);
    send_poll(8'd128, 32'hFFFF_FFF2, 0);
  endtask

  task automatic test_output_hold_off();
    hold_request <= 150;
    repeat (30) begin
      advance_stimulus();
      send_poll(stim_count, stim_now, 0);
    end
  endtask

  task automatic test_sender_pause();
    repeat (10) begin
      advance_stimulus();
      send_poll(stim_count, stim_now, pick_gap(1'b1));
    end
    settle_idle();
    repeat (10) begin
      advance_stimulus();
      send_poll(stim_count, stim_now, pick_gap(1'b1));
    end
  endtask

  task automatic test_random_phases();
    logic [6:0]  dz;
    logic [15:0] sus;
    logic        clr;
    logic        inv;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          dz = 7'd4; sus = 16'd100; clr = 1'b1; inv = 1'b1;
        end
        1: begin
          dz = 7'd0; sus = 16'd0; clr = 1'b0; inv = 1'b0;
        end
        2: begin
          dz = 7'd127; sus = 16'hFFFF; clr = 1'b1; inv = 1'b0;
        end
        3: begin
          dz = 7'd1; sus = 16'd1; clr = 1'b0; inv = 1'b1;
        end
        default: begin
          dz = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 8));
          sus = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, 300));
          clr = 1'($urandom);
          inv = 1'($urandom);
        end
      endcase
      settle_idle();
      write_register(ecdb_pkg::CFG_DEADZONE, {9'($urandom), dz});
      write_register(ecdb_pkg::CFG_HOLD_MS, sus);
      write_register(ecdb_pkg::CFG_CLEAR_REV, {15'($urandom), clr});
      write_register(ecdb_pkg::CFG_INVERT_OUT, {15'($urandom), inv});
      // one phase runs back to back with no sender gaps
      repeat (110) begin
        advance_stimulus();
        send_poll(stim_count, stim_now, pick_gap(p != 2));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_output_hold_off();
    test_sender_pause();
    test_random_phases();
    settle_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_polls.size() == 0) begin
      $display("tb_encoder_count_to_direction_button_core: PASS");
    end else begin
      $display("tb_encoder_count_to_direction_button_core: FAIL");
    end
    $finish;
  end

endmodule
